>>> design/wto_pkg.sv
// Shared types, constants and the microcode program of the wavetable oscillator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package wto_pkg;

    localparam int TABLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 20;

    localparam int SAMPLE_W     = 16;
    localparam int ADDR_IN_W    = 12;
    localparam int PHASE_INC_W  = 32;
    localparam int MOD_SCALE_W  = 24;
    localparam int GAIN_W       = 16;
    localparam int GAIN_FRAC    = 14;
    localparam int MOD_SHIFT    = 15;
    localparam int MUL_A_W      = SAMPLE_W + 1;
    localparam int S_TDATA_W    = 48;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC = 3'd0,
        CFG_MOD_SCALE = 3'd1,
        CFG_MOD_EN    = 3'd2,
        CFG_GAIN      = 3'd3,
        CFG_INTERP    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PHASE_INC_W-1:0] phase_inc;
        logic [MOD_SCALE_W-1:0] mod_scale;
        logic                   mod_enable;
        logic [GAIN_W-1:0]      gain;
        logic                   interp;
    } t_cfg;

    // Program steps of one tick.
    typedef enum logic [2:0] {
        ST_PH_INC = 3'd0,
        ST_PH_MOD = 3'd1,
        ST_LD_A   = 3'd2,
        ST_DIFF   = 3'd3,
        ST_MUL_F  = 3'd4,
        ST_LERP   = 3'd5,
        ST_GAIN   = 3'd6,
        ST_SAT    = 3'd7
    } t_step;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_MOD  = 2'd1,
        MUL_FRAC = 2'd2,
        MUL_GAIN = 2'd3
    } t_mul_sel;

    typedef enum logic [1:0] {
        PH_HOLD = 2'd0,
        PH_INC  = 2'd1,
        PH_MOD  = 2'd2
    } t_ph_op;

    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_CUR  = 2'd1,
        RD_NEXT = 2'd2
    } t_rd_sel;

    typedef enum logic {
        JMP_NONE      = 1'b0,
        JMP_NO_INTERP = 1'b1
    } t_jmp;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_ph_op   ph_op;
        t_rd_sel  rd_sel;
        logic     lat_a;
        logic     lat_diff;
        logic     lat_lerp;
        logic     out_load;
        t_jmp     jmp;
        t_step    target;
        logic     last;
    } t_ucode;

    localparam t_ucode UC_NOP = '{
        mul_sel:  MUL_NONE,
        ph_op:    PH_HOLD,
        rd_sel:   RD_NONE,
        lat_a:    1'b0,
        lat_diff: 1'b0,
        lat_lerp: 1'b0,
        out_load: 1'b0,
        jmp:      JMP_NONE,
        target:   ST_PH_INC,
        last:     1'b0
    };

    // Control store: one word per step.
    function automatic t_ucode uc_rom(input t_step step);
        t_ucode w;
        w = UC_NOP;
        unique case (step)
            ST_PH_INC: begin
                w.mul_sel = MUL_MOD;
                w.ph_op   = PH_INC;
            end
            ST_PH_MOD: begin
                w.ph_op  = PH_MOD;
                w.rd_sel = RD_CUR;
            end
            ST_LD_A: begin
                w.rd_sel = RD_NEXT;
                w.lat_a  = 1'b1;
                w.jmp    = JMP_NO_INTERP;
                w.target = ST_GAIN;
            end
            ST_DIFF:  w.lat_diff = 1'b1;
            ST_MUL_F: w.mul_sel  = MUL_FRAC;
            ST_LERP:  w.lat_lerp = 1'b1;
            ST_GAIN:  w.mul_sel  = MUL_GAIN;
            ST_SAT: begin
                w.out_load = 1'b1;
                w.last     = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> design/wto_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jump.
// Depends on wto_pkg for the step enum and the control word.
`timescale 1ns / 1ps
`default_nettype none

module wto_seq
    import wto_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire logic   i_interp,
    input  wire logic   i_out_free,
    output logic        o_busy,
    output t_ucode      o_ctrl
);

    logic   r_busy, n_busy;
    t_step  r_pc, n_pc;
    t_ucode w_cw;
    logic   w_stall;

    assign w_cw    = uc_rom(r_pc);
    assign w_stall = w_cw.out_load && !i_out_free;

    // next state
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = ST_PH_INC;
            end
        end else if (!w_stall) begin
            if (w_cw.last) begin
                n_busy = 1'b0;
            end else if (w_cw.jmp == JMP_NO_INTERP && !i_interp) begin
                n_pc = w_cw.target;
            end else begin
                n_pc = t_step'(r_pc + 3'd1);
            end
        end
    end

    // outputs; hold the result step while the output register is full
    always_comb begin
        o_busy = r_busy;
        o_ctrl = UC_NOP;
        if (r_busy && !w_stall) begin
            o_ctrl = w_cw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= ST_PH_INC;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

endmodule

`default_nettype wire

>>> design/wto_table.sv
// Wave table memory: one write port, one read port with registered data.
// Depends on wto_pkg for the word width. Contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module wto_table
    import wto_pkg::*;
#(
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [TABLE_BITS-1:0] i_waddr,
    input  wire logic [SAMPLE_W-1:0]   i_wdata,
    input  wire logic                  i_re,
    input  wire logic [TABLE_BITS-1:0] i_raddr,
    output logic      [SAMPLE_W-1:0]   o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [2**TABLE_BITS];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/wto_dpath.sv
// Oscillator datapath: phase accumulator, one shared multiplier, interpolation
// and saturation, driven by the control word. Depends on wto_pkg and wto_table.
`timescale 1ns / 1ps
`default_nettype none

module wto_dpath
    import wto_pkg::*;
#(
    parameter int TABLE_BITS = TABLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ucode                i_ctrl,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_start,
    input  wire logic [SAMPLE_W-1:0]   i_mod_sample,
    input  wire logic                  i_wr_en,
    input  wire logic [TABLE_BITS-1:0] i_wr_addr,
    input  wire logic [SAMPLE_W-1:0]   i_wr_data,
    output logic      [SAMPLE_W-1:0]   o_sample
);

    localparam int PHASE_BITS = TABLE_BITS + FRAC_BITS;
    localparam int MUL_B_W    = (FRAC_BITS > MOD_SCALE_W) ? FRAC_BITS : MOD_SCALE_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W + 1;

    logic        [PHASE_BITS-1:0] r_phase, n_phase;
    logic signed [SAMPLE_W-1:0]   r_mod;
    logic signed [SAMPLE_W-1:0]   r_a;
    logic signed [SAMPLE_W-1:0]   r_v;
    logic signed [MUL_A_W-1:0]    r_diff;
    logic signed [PROD_W-1:0]     r_prod;

    logic signed [MUL_A_W-1:0]    w_mul_a;
    logic        [MUL_B_W-1:0]    w_mul_b;
    logic signed [PROD_W-1:0]     w_off_full;
    logic        [PHASE_BITS-1:0] w_off;
    logic signed [PROD_W-1:0]     w_lerp_full;
    logic signed [PROD_W-1:0]     w_gain_full;
    logic [PROD_W-1-SAMPLE_W+1:0] w_gain_hi;
    logic        [TABLE_BITS-1:0] w_idx;
    logic        [TABLE_BITS-1:0] w_raddr;
    logic                         w_re;
    logic signed [SAMPLE_W-1:0]   w_rdata;

    // floor shifts of the shared product
    assign w_off_full  = r_prod >>> MOD_SHIFT;
    assign w_off       = PHASE_BITS'(w_off_full);
    assign w_lerp_full = r_prod >>> FRAC_BITS;
    assign w_gain_full = r_prod >>> GAIN_FRAC;

    always_comb begin
        unique case (i_ctrl.ph_op)
            PH_INC:  n_phase = r_phase + PHASE_BITS'(i_cfg.phase_inc);
            PH_MOD:  n_phase = i_cfg.mod_enable ? r_phase + w_off : r_phase;
            default: n_phase = r_phase;
        endcase
    end

    assign w_idx = r_phase[PHASE_BITS-1:FRAC_BITS];

    // first entry is read at the phase being written this cycle
    always_comb begin
        w_re = 1'b1;
        unique case (i_ctrl.rd_sel)
            RD_CUR:  w_raddr = n_phase[PHASE_BITS-1:FRAC_BITS];
            RD_NEXT: w_raddr = w_idx + TABLE_BITS'(1);
            default: begin
                w_raddr = w_idx;
                w_re    = 1'b0;
            end
        endcase
    end

    wto_table #(
        .TABLE_BITS (TABLE_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wr_data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        unique case (i_ctrl.mul_sel)
            MUL_MOD: begin
                w_mul_a = {r_mod[SAMPLE_W-1], r_mod};
                w_mul_b = MUL_B_W'(i_cfg.mod_scale);
            end
            MUL_FRAC: begin
                w_mul_a = r_diff;
                w_mul_b = MUL_B_W'(r_phase[FRAC_BITS-1:0]);
            end
            MUL_GAIN: begin
                w_mul_a = {r_v[SAMPLE_W-1], r_v};
                w_mul_b = MUL_B_W'(i_cfg.gain);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mod <= i_mod_sample;
        end
        if (i_ctrl.mul_sel != MUL_NONE) begin
            r_prod <= w_mul_a * $signed({1'b0, w_mul_b});
        end
        if (i_ctrl.lat_a) begin
            r_a <= w_rdata;
            r_v <= w_rdata;
        end
        if (i_ctrl.lat_diff) begin
            r_diff <= {w_rdata[SAMPLE_W-1], w_rdata} - {r_a[SAMPLE_W-1], r_a};
        end
        if (i_ctrl.lat_lerp) begin
            r_v <= r_a + w_lerp_full[SAMPLE_W-1:0];
        end
    end

    // saturate: in range when the sample's sign bit and all bits above it agree
    assign w_gain_hi = w_gain_full[PROD_W-1:SAMPLE_W-1];

    always_comb begin
        if (&w_gain_hi || ~|w_gain_hi) begin
            o_sample = w_gain_full[SAMPLE_W-1:0];
        end else if (w_gain_full[PROD_W-1]) begin
            o_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            o_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

>>> design/wavetable_oscillator_core.sv
// Top level of the wavetable oscillator: stream ports, configuration registers,
// output register. Depends on wto_pkg, wto_seq, wto_dpath (with wto_table).
//
//   Channel   Direction  Handshake                    Contents
//   s_axis    in         s_axis_tvalid/s_axis_tready  tuser: func; tdata: mod_sample,
//                                                     table_addr, table_data
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata: sample
//   cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// A table write does not start the program; the next item can be taken in the following cycle.
// A tick runs the microcode program, and no item is taken while it runs: every step
// with interpolation, a jump from the first read to the gain step with truncating lookup;
// the steps are set by the shared multiplier and the single read port of the table.
// Reset clears the phase and loads the configuration defaults; the table is not cleared.
// The last step holds while the output register is full and not taken.
`timescale 1ns / 1ps
`default_nettype none

module wavetable_oscillator_core
    import wto_pkg::*;
#(
    parameter int TABLE_BITS = TABLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] mod_sample, [27:16] table_addr, [43:28] table_data, [47:44] zero
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [15:0] sample
    output logic      [SAMPLE_W-1:0]   m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                r_cfg;
    logic                r_ovalid;
    logic [SAMPLE_W-1:0] r_odata;
    logic                w_busy;
    t_ucode              w_ctrl;
    logic                w_accept;
    logic                w_start;
    logic                w_wr;
    logic                w_out_free;
    logic [SAMPLE_W-1:0] w_sample;
    logic [SAMPLE_W-1:0] w_mod_sample;
    logic [ADDR_IN_W-1:0] w_tab_addr;
    logic [SAMPLE_W-1:0] w_tab_data;

    assign s_axis_tready = !w_busy;
    assign o_cfg_ready   = 1'b1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_start       = w_accept && !s_axis_tuser;
    assign w_wr          = w_accept && s_axis_tuser;
    assign w_out_free    = !r_ovalid || m_axis_tready;

    assign w_mod_sample = s_axis_tdata[SAMPLE_W-1:0];
    assign w_tab_addr   = s_axis_tdata[SAMPLE_W+ADDR_IN_W-1:SAMPLE_W];
    assign w_tab_data   = s_axis_tdata[2*SAMPLE_W+ADDR_IN_W-1:SAMPLE_W+ADDR_IN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_inc  <= '0;
            r_cfg.mod_scale  <= '0;
            r_cfg.mod_enable <= 1'b0;
            r_cfg.gain       <= GAIN_RESET;
            r_cfg.interp     <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PHASE_INC: r_cfg.phase_inc  <= i_cfg_data;
                CFG_MOD_SCALE: r_cfg.mod_scale  <= i_cfg_data[MOD_SCALE_W-1:0];
                CFG_MOD_EN:    r_cfg.mod_enable <= i_cfg_data[0];
                CFG_GAIN:      r_cfg.gain       <= i_cfg_data[GAIN_W-1:0];
                CFG_INTERP:    r_cfg.interp     <= i_cfg_data[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    wto_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_interp   (r_cfg.interp),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_ctrl     (w_ctrl)
    );

    wto_dpath #(
        .TABLE_BITS (TABLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_cfg        (r_cfg),
        .i_start      (w_start),
        .i_mod_sample (w_mod_sample),
        .i_wr_en      (w_wr),
        .i_wr_addr    (TABLE_BITS'(w_tab_addr)),
        .i_wr_data    (w_tab_data),
        .o_sample     (w_sample)
    );

    // output register parts the sequencer from the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_load) begin
            r_odata <= w_sample;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_result_from_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_ctrl.out_load))
        else $error("result shown without a result step");

    a_tick_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !s_axis_tready)
        else $error("input taken while a tick runs");

    a_write_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> s_axis_tready && !w_ctrl.out_load)
        else $error("table write started the program");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_load |-> !r_ovalid || m_axis_tready)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> tb/tb_wavetable_oscillator_core.sv
// Self-checking testbench for wavetable_oscillator_core: a directed table, then random
// ticks and table writes under several idling mixes, checked against a fixed-point predictor.
// Depends on wto_pkg and the RTL of the oscillator core only.
`timescale 1ns / 1ps

module tb_wavetable_oscillator_core;
    import wto_pkg::*;

    localparam int PHASE_W         = TABLE_BITS_DEF + FRAC_BITS_DEF;
    localparam int TABLE_SIZE      = 1 << TABLE_BITS_DEF;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_BLOCKS      = 16;
    localparam int ITEMS_PER_BLOCK = 20;
    localparam int NUM_ROWS        = 38;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Indexes past the register list; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        ROW_CFG   = 2'd0,
        ROW_WRITE = 2'd1,
        ROW_TICK  = 2'd2
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [SAMPLE_W-1:0]    mod;
        logic [ADDR_IN_W-1:0]   addr;
        logic [SAMPLE_W-1:0]    data;
        logic                   known;
        logic [SAMPLE_W-1:0]    sample;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Typed-in expectation travelling with the item on the input bus.
    logic                  pin_known = 1'b0;
    logic [SAMPLE_W-1:0]   pin_sample = '0;

    // Oscillator state as predicted.
    logic [PHASE_W-1:0]     osc_phase = '0;
    logic [SAMPLE_W-1:0]    wave_mem [TABLE_SIZE];
    logic [PHASE_INC_W-1:0] reg_phase_inc = '0;
    logic [MOD_SCALE_W-1:0] reg_mod_scale = '0;
    logic                   reg_mod_en = 1'b0;
    logic [GAIN_W-1:0]      reg_gain = GAIN_RESET;
    logic                   reg_interp = 1'b1;

    // Sender's own view: phase after the last tick sent, entries already loaded.
    logic [PHASE_W-1:0]     drv_phase = '0;
    logic                   table_loaded [TABLE_SIZE];

    logic [SAMPLE_W-1:0] expected_samples [$];
    int                  error_count = 0;
    int                  idle_cycles = 0;

    int          send_idle_pct = 0;
    int          sink_stall_pct = 0;
    logic [7:0]  hold_token = '0;
    logic [7:0]  hold_seen = '0;
    int          hold_left = 0;

    t_stim_row directed_rows [NUM_ROWS];

    wavetable_oscillator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_PHASE_INC: reg_phase_inc = val;
            CFG_MOD_SCALE: reg_mod_scale = val[MOD_SCALE_W-1:0];
            CFG_MOD_EN:    reg_mod_en    = val[0];
            CFG_GAIN:      reg_gain      = val[GAIN_W-1:0];
            CFG_INTERP:    reg_interp    = val[0];
            default: ;
        endcase
    endfunction

    // Phase after one tick from the given phase with the current registers.
    function automatic logic [PHASE_W-1:0] step_phase(input logic [PHASE_W-1:0] ph,
                                                      input logic [SAMPLE_W-1:0] mod_in);
        logic signed [47:0] offset;
        logic [PHASE_W-1:0] nxt_ph;
        nxt_ph = ph + reg_phase_inc;
        if (reg_mod_en) begin
            // floor division by 2^15 through the arithmetic shift
            offset = ($signed({{32{mod_in[SAMPLE_W-1]}}, mod_in})
                      * $signed({24'd0, reg_mod_scale})) >>> MOD_SHIFT;
            nxt_ph = nxt_ph + offset[PHASE_W-1:0];
        end
        return nxt_ph;
    endfunction

    // Advance the phase by one tick and return the sample it reads out.
    function automatic logic [SAMPLE_W-1:0] advance_oscillator(input logic [SAMPLE_W-1:0] mod_in);
        logic signed [47:0]         a_ext;
        logic signed [47:0]         b_ext;
        logic signed [47:0]         level;
        logic signed [47:0]         scaled;
        logic [TABLE_BITS_DEF-1:0]  idx;
        logic [TABLE_BITS_DEF-1:0]  nxt;
        logic [FRAC_BITS_DEF-1:0]   frac;
        osc_phase = step_phase(osc_phase, mod_in);
        idx   = osc_phase[PHASE_W-1 -: TABLE_BITS_DEF];
        frac  = osc_phase[FRAC_BITS_DEF-1:0];
        nxt   = idx + 1'b1;
        a_ext = $signed({{32{wave_mem[idx][SAMPLE_W-1]}}, wave_mem[idx]});
        b_ext = $signed({{32{wave_mem[nxt][SAMPLE_W-1]}}, wave_mem[nxt]});
        if (reg_interp) begin
            level = ((a_ext <<< FRAC_BITS_DEF)
                     + (b_ext - a_ext) * $signed({28'd0, frac})) >>> FRAC_BITS_DEF;
        end else begin
            level = a_ext;
        end
        scaled = (level * $signed({32'd0, reg_gain})) >>> GAIN_FRAC;
        if (scaled > 32767)
            return 16'h7FFF;
        if (scaled < -32768)
            return 16'h8000;
        return scaled[SAMPLE_W-1:0];
    endfunction

    // Check results, predict accepted items, track register writes, watch for hangs.
    always @(posedge i_clk) begin : monitor
        logic [SAMPLE_W-1:0] want;
        logic [SAMPLE_W-1:0] predicted;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected sample, expected none, actual %0d",
                             $time, $signed(m_axis_tdata));
                    error_count = error_count + 1;
                end else begin
                    want = expected_samples.pop_front();
                    if (m_axis_tdata !== want) begin
                        $display("%0t: sample mismatch, expected %0d, actual %0d",
                                 $time, $signed(want), $signed(m_axis_tdata));
                        error_count = error_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == FUNC_WRITE) begin
                    wave_mem[s_axis_tdata[27:16]] = s_axis_tdata[43:28];
                end else begin
                    predicted = advance_oscillator(s_axis_tdata[15:0]);
                    expected_samples.push_back(pin_known ? pin_sample : predicted);
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                apply_reg(i_cfg_index, i_cfg_data);

            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Output side: random stalls, plus one long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_seen != hold_token) begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic push_item(input logic fn, input logic [SAMPLE_W-1:0] mod_in,
                             input logic [ADDR_IN_W-1:0] addr_in,
                             input logic [SAMPLE_W-1:0] data_in,
                             input logic known, input logic [SAMPLE_W-1:0] known_sample);
        if (fn == FUNC_WRITE)
            table_loaded[addr_in] = 1'b1;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {4'b0, data_in, addr_in, mod_in};
        pin_known     <= known;
        pin_sample    <= known_sample;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Load the entries the tick is about to read if they were never written, then tick.
    task automatic push_tick(input logic [SAMPLE_W-1:0] mod_in,
                             input logic [ADDR_IN_W-1:0] addr_in,
                             input logic [SAMPLE_W-1:0] data_in,
                             input logic known, input logic [SAMPLE_W-1:0] known_sample);
        logic [PHASE_W-1:0]        ph;
        logic [TABLE_BITS_DEF-1:0] idx;
        ph  = step_phase(drv_phase, mod_in);
        idx = ph[PHASE_W-1 -: TABLE_BITS_DEF];
        if (!table_loaded[idx])
            push_item(FUNC_WRITE, '0, idx, SAMPLE_W'($urandom), 1'b0, '0);
        idx = idx + 1'b1;
        if (reg_interp && !table_loaded[idx])
            push_item(FUNC_WRITE, '0, idx, SAMPLE_W'($urandom), 1'b0, '0);
        drv_phase = ph;
        push_item(FUNC_TICK, mod_in, addr_in, data_in, known, known_sample);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain: wait out every pending sample, then let a trailing table write finish.
    task automatic settle_idle;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] val;
        t_stim_row             row;

        directed_rows = '{
            '{ROW_WRITE, '0, '0, 16'hFFFF, 12'h000, 16'h7FFF, 1'b0, '0},
            '{ROW_WRITE, '0, '0, 16'h0000, 12'h001, 16'h8000, 1'b0, '0},
            '{ROW_WRITE, '0, '0, 16'h8000, 12'hFFF, 16'h0000, 1'b0, '0},
            // reset settings, phase 0: entry 0 straight out
            '{ROW_TICK, '0, '0, 16'h8000, 12'hFFF, 16'hFFFF, 1'b1, 16'h7FFF},
            '{ROW_CFG, CFG_GAIN, 32'h0000_FFFF, '0, '0, '0, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'h7FFF, 12'h000, 16'h0000, 1'b1, 16'h7FFF},
            '{ROW_CFG, CFG_PHASE_INC, 32'h0010_0000, '0, '0, '0, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'h0000, 12'h000, 16'h0000, 1'b1, 16'h8000},
            '{ROW_CFG, CFG_GAIN, 32'h0000_0000, '0, '0, '0, 1'b0, '0},
            '{ROW_CFG, CFG_PHASE_INC, 32'hFFF0_0000, '0, '0, '0, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'h0000, 12'h000, 16'h0000, 1'b1, 16'h0000},
            '{ROW_CFG, CFG_GAIN, 32'h0000_4000, '0, '0, '0, 1'b0, '0},
            // phase wraps below zero onto the last entry
            '{ROW_TICK, '0, '0, 16'h0000, 12'h000, 16'h0000, 1'b1, 16'h0000},
            '{ROW_CFG, CFG_PHASE_INC, 32'h0008_0000, '0, '0, '0, 1'b0, '0},
            // blend between the last entry and entry 0
            '{ROW_TICK, '0, '0, 16'h0000, 12'h000, 16'h0000, 1'b1, 16'h3FFF},
            '{ROW_TICK, '0, '0, 16'h0000, 12'h000, 16'h0000, 1'b1, 16'h7FFF},
            // halfway between full scale values floors to -1
            '{ROW_TICK, '0, '0, 16'h0000, 12'h000, 16'h0000, 1'b1, 16'hFFFF},
            '{ROW_CFG, CFG_INTERP, 32'h0000_0000, '0, '0, '0, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'h0000, 12'h000, 16'h0000, 1'b1, 16'h8000},
            // truncating lookup must use the updated phase
            '{ROW_TICK, '0, '0, 16'h0000, 12'h000, 16'h0000, 1'b1, 16'h8000},
            '{ROW_CFG, CFG_SPARE_LO, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0},
            '{ROW_CFG, CFG_SPARE_HI, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'h0000, 12'hFFF, 16'hFFFF, 1'b0, '0},
            '{ROW_CFG, CFG_MOD_SCALE, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0},
            '{ROW_CFG, CFG_MOD_EN, 32'h0000_0001, '0, '0, '0, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'h7FFF, 12'h000, 16'h0000, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'h8000, 12'h000, 16'h0000, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'hFFFF, 12'h000, 16'h0000, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'h0001, 12'h000, 16'h0000, 1'b0, '0},
            '{ROW_CFG, CFG_INTERP, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'h8000, 12'h000, 16'h0000, 1'b0, '0},
            // upper bits are masked off: this turns modulation off
            '{ROW_CFG, CFG_MOD_EN, 32'hFFFF_FFFE, '0, '0, '0, 1'b0, '0},
            '{ROW_CFG, CFG_PHASE_INC, 32'h8000_0000, '0, '0, '0, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'h7FFF, 12'h000, 16'h0000, 1'b0, '0},
            '{ROW_CFG, CFG_PHASE_INC, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, '0},
            '{ROW_TICK, '0, '0, 16'h0000, 12'hAAA, 16'h5555, 1'b0, '0},
            '{ROW_WRITE, '0, '0, 16'h5555, 12'hAAA, 16'h5555, 1'b0, '0},
            '{ROW_WRITE, '0, '0, 16'hAAAA, 12'h555, 16'hAAAA, 1'b0, '0}
        };

        for (int entry = 0; entry < TABLE_SIZE; entry++)
            table_loaded[entry] = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = directed_rows[r];
            case (row.kind)
                ROW_CFG: begin
                    settle_idle();
                    write_reg(row.reg_idx, row.reg_val);
                end
                ROW_WRITE: push_item(FUNC_WRITE, row.mod, row.addr, row.data, 1'b0, '0);
                default:   push_tick(row.mod, row.addr, row.data, row.known, row.sample);
            endcase
        end

        for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
            settle_idle();
            case (blk / 4)
                0: begin
                    send_idle_pct = 0;
                    sink_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 59;
                    sink_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    sink_stall_pct <= 59;
                end
                default: begin
                    send_idle_pct = 32;
                    sink_stall_pct <= 32;
                end
            endcase
            // hold the output off long enough to back the input up
            if (blk == 1)
                hold_token <= hold_token + 1'b1;

            case ($urandom_range(3))
                0:       val = $urandom;
                1:       val = $urandom_range(32'h003F_FFFF);
                2:       val = 32'h8000_0000;
                default: val = 32'hFFFF_FFFF;
            endcase
            write_reg(CFG_PHASE_INC, val);
            case ($urandom_range(2))
                0:       val = '0;
                1:       val = 32'h00FF_FFFF;
                default: val = $urandom;
            endcase
            write_reg(CFG_MOD_SCALE, val);
            write_reg(CFG_MOD_EN, $urandom);
            case ($urandom_range(3))
                0:       val = '0;
                1:       val = 32'h0000_FFFF;
                2:       val = {16'd0, GAIN_RESET};
                default: val = $urandom;
            endcase
            write_reg(CFG_GAIN, val);
            write_reg(CFG_INTERP, $urandom);

            repeat (ITEMS_PER_BLOCK) begin
                if ($urandom_range(99) < 15)
                    push_item(FUNC_WRITE, SAMPLE_W'($urandom), ADDR_IN_W'($urandom),
                              SAMPLE_W'($urandom), 1'b0, '0);
                else
                    push_tick(SAMPLE_W'($urandom), ADDR_IN_W'($urandom),
                              SAMPLE_W'($urandom), 1'b0, '0);
            end
        end

        settle_idle();
        if (error_count == 0 && expected_samples.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
design/wto_pkg.sv
design/wto_seq.sv
design/wto_table.sv
design/wto_dpath.sv
design/wavetable_oscillator_core.sv
tb/tb_wavetable_oscillator_core.sv
